/* rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when synthesizing.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion lbl failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("assertion lbl failed");
`else
`define ASSERT_AT(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif

`endif

/* rtl/k32rre_pkg.sv */
// ------------------------------------------------------------------------
// k32rre_pkg
// Constants and the round-constant table for the KATAN32 round engine.
// ------------------------------------------------------------------------
package k32rre_pkg;

  localparam int MaxRoundsDef = 254;
  localparam int KeyW         = 80;
  localparam int StateW       = 32;
  localparam int RndW         = 8;

  // IR sequence, round 0 is the leftmost bit
  localparam logic [0:253] IrSeq = {
    55'b1111111000_1101010101_1110110011_0010100100_0100011000_11110,
    56'b0001000010_1000001111_1001111110_1010001010_1001100001_100111,
    56'b0111110111_0100101011_0100111001_1011000101_1101101111_001011,
    56'b0110101110_0100100110_1000111000_1001111010_0001110101_100000,
    31'b1011001000_0001101110_0000001001_0
  };

  function automatic logic ir_bit(input logic [RndW-1:0] rnd);
    ir_bit = IrSeq[rnd];
  endfunction

endpackage

/* rtl/katan32_round_range_encrypt.sv */
// ------------------------------------------------------------------------
// katan32_round_range_encrypt
// KATAN32 encryption over a window of rounds, one round per clock.
// ------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    plaintext, first_round, round_count
// out      output     out_valid / out_ready  ciphertext, clipped
// cfg      input      cfg_we                 cfg_index, cfg_wdata (key halves)
//
// The engine runs rounds 0 to last-1, last = min(first_round + round_count, MAX_ROUNDS)
// (zero when round_count is zero). The key LFSR steps two bits per cycle
// from round 0, so rounds below first_round are still stepped through.
// in_ready is high only when idle; the result holds until out_ready.
// rst_n is synchronous; it clears control state and both key registers.
`include "assert_macros.svh"

module katan32_round_range_encrypt #(
  parameter int MAX_ROUNDS = k32rre_pkg::MaxRoundsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_plaintext,
  input  logic [7:0]  in_first_round,
  input  logic [7:0]  in_round_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_ciphertext,
  output logic        out_clipped,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int RndW = k32rre_pkg::RndW;
  localparam logic [RndW-1:0] MaxR = RndW'(MAX_ROUNDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  logic [63:0] key_low_r;
  logic [15:0] key_high_r;

  logic [1:0]                     state_r, state_nxt;
  logic [k32rre_pkg::StateW-1:0]  s_r, s_nxt;
  logic [k32rre_pkg::KeyW-1:0]    ks_r, ks_nxt;
  logic [RndW-1:0]                rnd_r, rnd_nxt;
  logic [RndW-1:0]                first_r, first_nxt;
  logic [RndW-1:0]                last_r, last_nxt;
  logic                           clipped_r, clipped_nxt;

  logic            in_acc;
  logic [RndW:0]   win_end;
  logic            win_clip;
  logic [RndW-1:0] win_last;
  logic            fa, fb, ka, kb;
  logic [k32rre_pkg::StateW-1:0] s_round;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        REG_KEY_HIGH: key_high_r <= cfg_wdata[15:0];
        default:      key_low_r  <= key_low_r;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign in_acc    = in_valid && in_ready;

  assign win_end  = {1'b0, in_first_round} + {1'b0, in_round_count};
  assign win_clip = (in_round_count != '0) && (win_end > {1'b0, MaxR});
  assign win_last = (in_round_count == '0) ? '0 : (win_clip ? MaxR : win_end[RndW-1:0]);

  // round function on the current window of key stream bits
  assign ka = ks_r[0];
  assign kb = ks_r[1];
  assign fa = s_r[31] ^ s_r[26] ^ (s_r[27] & s_r[24])
            ^ (s_r[22] & k32rre_pkg::ir_bit(rnd_r)) ^ ka;
  assign fb = s_r[18] ^ s_r[7] ^ (s_r[12] & s_r[10]) ^ (s_r[8] & s_r[3]) ^ kb;
  assign s_round = {s_r[30:19], fb, s_r[17:0], fa};

  always_comb begin
    state_nxt   = state_r;
    s_nxt       = s_r;
    ks_nxt      = ks_r;
    rnd_nxt     = rnd_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    clipped_nxt = clipped_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          s_nxt       = in_plaintext;
          ks_nxt      = {key_high_r, key_low_r};
          rnd_nxt     = '0;
          first_nxt   = in_first_round;
          last_nxt    = win_last;
          clipped_nxt = win_clip;
          state_nxt   = (win_last == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (rnd_r >= first_r) begin
          s_nxt = s_round;
        end
        // k[i+80] and k[i+81]
        ks_nxt = {ks_r[1] ^ ks_r[20] ^ ks_r[31] ^ ks_r[68],
                  ks_r[0] ^ ks_r[19] ^ ks_r[30] ^ ks_r[67],
                  ks_r[79:2]};
        rnd_nxt = rnd_r + RndW'(1);
        if (rnd_nxt == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    ks_r      <= ks_nxt;
    rnd_r     <= rnd_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    clipped_r <= clipped_nxt;
  end

  assign out_ciphertext = s_r;
  assign out_clipped    = clipped_r;

  `ASSERT_NEVER(a_ready_and_valid, clk, rst_n, in_ready && out_valid)
  `ASSERT_AT(a_rnd_in_window, clk, rst_n, (state_r == ST_RUN) |-> (rnd_r < last_r))
  `ASSERT_AT(a_clip_at_max, clk, rst_n, (state_r != ST_IDLE && clipped_r) |-> (last_r == MaxR))
  `ASSERT_AT(a_zero_count_passes, clk, rst_n,
    (in_valid && in_ready && in_round_count == '0) |=>
      (out_valid && !out_clipped && out_ciphertext == $past(in_plaintext)))

endmodule

/* dv/tb_katan32_round_range_encrypt.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// KATAN32 round-window encryption testbench
// Sends plaintext requests over windows of rounds under several keys and
// checks each ciphertext and clip flag against a round-by-round predictor.
// ----------------------------------------------------------------------------
module tb_katan32_round_range_encrypt;

  localparam int CLK_PERIOD     = 12;
  localparam int ROUND_LIMIT    = 254;
  localparam int KEY_STREAM_LEN = 508;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int MAX_REPORTS    = 200;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 255;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // KATAN round-constant sequence, round 0 first
  localparam logic [0:253] ROUND_CONST = {
    55'b1111111000_1101010101_1110110011_0010100100_0100011000_11110,
    56'b0001000010_1000001111_1001111110_1010001010_1001100001_100111,
    56'b0111110111_0100101011_0100111001_1011000101_1101101111_001011,
    56'b0110101110_0100100110_1000111000_1001111010_0001110101_100000,
    31'b1011001000_0001101110_0000001001_0
  };

  typedef struct packed {
    logic [31:0] ciphertext;
    logic        clipped;
  } cipher_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_plaintext;
  logic [7:0]  in_first_round;
  logic [7:0]  in_round_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_ciphertext;
  logic        out_clipped;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;

  logic [63:0]    key_low_q;
  logic [15:0]    key_high_q;
  cipher_result_t expected_q[$];
  int             error_count = 0;
  int             idle_cycles = 0;
  int             burst_left;

  katan32_round_range_encrypt DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_plaintext   (in_plaintext),
    .in_first_round (in_first_round),
    .in_round_count (in_round_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ciphertext (out_ciphertext),
    .out_clipped    (out_clipped),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Encrypt over [first, first+count), clipped at the last round
  function automatic cipher_result_t katan_window(input logic [31:0] plaintext,
                                                  input logic [7:0]  first,
                                                  input logic [7:0]  count);
    logic [0:KEY_STREAM_LEN-1] key_stream;
    logic [31:0]               s;
    logic                      fa;
    logic                      fb;
    int                        last;
    cipher_result_t            res;
    for (int i = 0; i < 64; i++) key_stream[i] = key_low_q[i];
    for (int i = 0; i < 16; i++) key_stream[64 + i] = key_high_q[i];
    for (int i = 80; i < KEY_STREAM_LEN; i++) begin
      key_stream[i] = key_stream[i-80] ^ key_stream[i-61] ^ key_stream[i-50]
                    ^ key_stream[i-13];
    end
    s           = plaintext;
    last        = int'(first) + int'(count);
    res.clipped = 1'b0;
    if (count != 8'd0 && last > ROUND_LIMIT) begin
      res.clipped = 1'b1;
      last        = ROUND_LIMIT;
    end
    for (int r = int'(first); r < last && r < ROUND_LIMIT; r++) begin
      fa = s[31] ^ s[26] ^ (s[27] & s[24]) ^ (s[22] & ROUND_CONST[r])
         ^ key_stream[2*r];
      fb = s[18] ^ s[7] ^ (s[12] & s[10]) ^ (s[8] & s[3]) ^ key_stream[2*r+1];
      s     = {s[30:0], s[31]};
      s[0]  = fa;
      s[19] = fb;
    end
    res.ciphertext = s;
    return res;
  endfunction

  // Key shadow, result check and prediction all on the same edge
  always @(posedge clk) begin : scoreboard
    cipher_result_t exp_r;
    if (!rst_n) begin
      key_low_q  = '0;
      key_high_q = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LOW:  key_low_q  = cfg_wdata;
          REG_KEY_HIGH: key_high_q = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result ciphertext %h clipped %b", $time,
                     out_ciphertext, out_clipped);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ciphertext !== exp_r.ciphertext) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: ciphertext mismatch expected %h actual %h", $time,
                       exp_r.ciphertext, out_ciphertext);
          end
          if (out_clipped !== exp_r.clipped) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: clipped mismatch expected %b actual %b", $time,
                       exp_r.clipped, out_clipped);
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(katan_window(in_plaintext, in_first_round, in_round_count));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver backpressure: modes of random length
  initial begin : result_stall
    int mode;
    int span;
    int phase;
    mode      = 0;
    span      = 0;
    phase     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
      end
      span--;
      phase++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ((phase % 17) >= 9);
      endcase
    end
  end

  // Called and returns on a falling edge; valid stays up into a burst
  task automatic send_request(input logic [31:0] plaintext,
                              input logic [7:0]  first,
                              input logic [7:0]  count);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_plaintext   <= plaintext;
    in_first_round <= first;
    in_round_count <= count;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] low, input logic [63:0] high);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_wdata <= low;
    @(negedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_wdata <= high;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Zero key from reset: full cipher, pass-through, windows at both ends, clipping
  task automatic test_directed_windows();
    send_request(32'h0000_0000, 8'd0,   8'd254);
    send_request(32'hFFFF_FFFF, 8'd0,   8'd254);
    send_request(32'h1234_5678, 8'd0,   8'd0);
    send_request(32'hFFFF_FFFF, 8'd253, 8'd1);
    send_request(32'hA5A5_A5A5, 8'd253, 8'd2);
    send_request(32'h0000_0000, 8'd254, 8'd0);
    send_request(32'hFFFF_FFFF, 8'd255, 8'd255);
    send_request(32'hDEAD_BEEF, 8'd254, 8'd1);
    send_request(32'h8000_0001, 8'd0,   8'd1);
    send_request(32'hFFFF_FFFF, 8'd0,   8'd255);
    send_request(32'h0F0F_0F0F, 8'd128, 8'd127);
    send_request(32'hF0F0_F0F0, 8'd100, 8'd154);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    write_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'h0000_0000, 8'd0,   8'd254);
    send_request(32'hFFFF_FFFF, 8'd0,   8'd254);
    send_request(32'h3C3C_3C3C, 8'd200, 8'd60);
    send_request(32'hC3C3_C3C3, 8'd127, 8'd128);
    wait_drained();
    // upper write-data bits of the high half must be dropped
    write_key(64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_0000_1234_5555);
    send_request(32'h5555_AAAA, 8'd0,   8'd254);
    send_request(32'hAAAA_5555, 8'd17,  8'd200);
    send_request(32'h0001_0000, 8'd250, 8'd3);
    wait_drained();
  endtask

  task automatic test_random_windows();
    logic [31:0] plaintext;
    logic [7:0]  first;
    logic [7:0]  count;
    int          pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1)
        write_key(64'd0, 64'd0);
      else
        write_key({$urandom, $urandom}, {$urandom, $urandom});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        plaintext = $urandom;
        pick      = $urandom_range(0, 9);
        if (pick <= 5) begin
          first = 8'($urandom_range(0, 255));
          count = 8'($urandom_range(0, 255));
        end else if (pick <= 7) begin
          // windows around the end of the schedule
          first = 8'($urandom_range(230, 255));
          count = 8'($urandom_range(0, 40));
        end else if (pick == 8) begin
          first = 8'd0;
          count = 8'($urandom_range(250, 255));
        end else begin
          first = 8'($urandom_range(0, 20));
          count = 8'($urandom_range(0, 8));
        end
        send_request(plaintext, first, count);
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_plaintext   = '0;
    in_first_round = '0;
    in_round_count = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_KEY_LOW;
    cfg_wdata      = '0;
    burst_left     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_windows();
    test_key_extremes();
    test_random_windows();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
